// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define BMPL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset too.
`define BMPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bmpl_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpl_pkg
// Types and constants of the Lucas binomial residue unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bmpl_pkg;

  localparam int unsigned ARG_W = 63;
  localparam int unsigned MOD_W = 21;
  localparam int unsigned RES_W = 20;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned BIT_W = 5;

  localparam logic REG_PRIME_MODULUS = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BF,
    ST_PW_SQ,
    ST_PW_ML,
    ST_BI,
    ST_CHK,
    ST_DIV,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             start;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic             done;
    logic [ARG_W-1:0] qn;
    logic [ARG_W-1:0] qm;
    logic [RES_W-1:0] rn;
    logic [RES_W-1:0] rm;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/bmpl_ram.sv =====
// ----------------------------------------------------------------------------
// bmpl_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bmpl_ram #(
  parameter int unsigned DEPTH = 1048576,
  parameter int unsigned W     = 20,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/bmpl_modmul.sv =====
// ----------------------------------------------------------------------------
// bmpl_modmul
// Shift-add modular multiplier, one bit of b per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bmpl_modmul
  import bmpl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [MOD_W-1:0] p_i,
  input  wire mul_req_t         req_i,
  output mul_rsp_t              rsp_o
);

  logic [RES_W-1:0] a_q, a_d, b_q, b_d;
  logic [MOD_W-1:0] acc_q, acc_d;
  logic [BIT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [MOD_W:0]   t0, t1, t2, p_x;

  assign p_x = {1'b0, p_i};

  always_comb begin
    t0 = {acc_q, 1'b0} + (b_q[RES_W-1] ? {2'b00, a_q} : '0);
    t1 = (t0 >= p_x) ? t0 - p_x : t0;
    t2 = (t1 >= p_x) ? t1 - p_x : t1;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = '0;
      cnt_d  = BIT_W'(RES_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = t2[MOD_W-1:0];
      b_d   = {b_q[RES_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q[RES_W-1:0];

endmodule
`default_nettype wire

// ===== sv/bmpl_divider.sv =====
// ----------------------------------------------------------------------------
// bmpl_divider
// Restoring divider, splits n and m by p together, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bmpl_divider
  import bmpl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ARG_W-1:0] n_i,
  input  wire logic [ARG_W-1:0] m_i,
  input  wire logic [MOD_W-1:0] p_i,
  output div_rsp_t              rsp_o
);

  logic [ARG_W-1:0] qn_q, qn_d, qm_q, qm_d;
  logic [MOD_W-1:0] rn_q, rn_d, rm_q, rm_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [MOD_W:0]   tn, tm, p_x;

  assign p_x = {1'b0, p_i};

  always_comb begin
    tn = {rn_q, qn_q[ARG_W-1]};
    tm = {rm_q, qm_q[ARG_W-1]};
    qn_d   = qn_q;
    qm_d   = qm_q;
    rn_d   = rn_q;
    rm_d   = rm_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      qn_d   = n_i;
      qm_d   = m_i;
      rn_d   = '0;
      rm_d   = '0;
      cnt_d  = CNT_W'(ARG_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (tn >= p_x) begin
        rn_d = MOD_W'(tn - p_x);
        qn_d = {qn_q[ARG_W-2:0], 1'b1};
      end else begin
        rn_d = tn[MOD_W-1:0];
        qn_d = {qn_q[ARG_W-2:0], 1'b0};
      end
      if (tm >= p_x) begin
        rm_d = MOD_W'(tm - p_x);
        qm_d = {qm_q[ARG_W-2:0], 1'b1};
      end else begin
        rm_d = tm[MOD_W-1:0];
        qm_d = {qm_q[ARG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qn_q <= qn_d;
    qm_q <= qm_d;
    rn_q <= rn_d;
    rm_q <= rm_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.qn   = qn_q;
  assign rsp_o.qm   = qm_q;
  assign rsp_o.rn   = rn_q[RES_W-1:0];
  assign rsp_o.rm   = rm_q[RES_W-1:0];

endmodule
`default_nettype wire

// ===== sv/binomial_mod_prime_lucas_unit.sv =====
// ----------------------------------------------------------------------------
// binomial_mod_prime_lucas_unit
// C(n, m) mod p by Lucas' theorem over factorial and inverse tables in memory.
// ----------------------------------------------------------------------------
// Per base-p digit: a divide, three table reads, then three modular multiplies;
//   up to 63 digits per word.
// First word after a modulus write also builds the tables.
// One word at a time; a finished result waits in the output register.
// Reset: modulus 2, tables marked not built; table memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module binomial_mod_prime_lucas_unit
  import bmpl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1048576
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [62:0] top_value, [125:63] bottom_value, [127:126] zero
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [19:0] binomial_residue, [23:20] zero
  output logic      [23:0]  m_axis_tdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  state_e           state_q, state_d;
  logic [MOD_W-1:0] p_q, p_d;
  logic             rdy_q, rdy_d;
  logic [ARG_W-1:0] n_q, n_d, m_q, m_d;
  logic [RES_W-1:0] acc_q, acc_d, f_q, f_d, g_q, g_d, pa_q, pa_d;
  logic [RES_W-1:0] fa_q, fa_d, ib_q, ib_d, ic_q, ic_d, rn_q, rn_d, rm_q, rm_d;
  logic [MOD_W-1:0] i_q, i_d;
  logic [BIT_W-1:0] k_q, k_d;
  logic             mpend_q, mpend_d, dpend_q, dpend_d;
  logic             ov_q, ov_d;
  logic [RES_W-1:0] od_q, od_d;

  mul_req_t         mreq;
  mul_rsp_t         mrsp;
  div_rsp_t         drsp;
  logic             div_start;
  logic             mul_start;

  logic             f_we, g_we;
  logic [AW-1:0]    f_waddr, g_waddr, f_raddr, g_raddr;
  logic [RES_W-1:0] f_wdata, g_wdata, f_rdata, g_rdata;

  logic             p_ok, in_acc, apb_wr;
  logic [RES_W-1:0] e_pw;
  logic [31:0]      p_ext;

  assign p_ext  = 32'(p_q);
  assign p_ok   = (p_q >= MOD_W'(2)) && (p_ext <= 32'(TABLE_DEPTH));
  assign e_pw   = RES_W'(p_q - MOD_W'(2));
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign apb_wr = psel && penable && pwrite && pready;

  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_PRIME_MODULUS) ? 32'(p_q) : '0;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = 24'(od_q);

  always_comb begin
    mreq.start = mul_start;
    mreq.a = '0;
    mreq.b = '0;
    case (state_q)
      ST_BF:    begin mreq.a = f_q;   mreq.b = i_q[RES_W-1:0]; end
      ST_PW_SQ: begin mreq.a = pa_q;  mreq.b = pa_q;           end
      ST_PW_ML: begin mreq.a = pa_q;  mreq.b = f_q;            end
      ST_BI:    begin mreq.a = g_q;   mreq.b = i_q[RES_W-1:0]; end
      ST_M1:    begin mreq.a = acc_q; mreq.b = fa_q;           end
      ST_M2:    begin mreq.a = acc_q; mreq.b = ib_q;           end
      ST_M3:    begin mreq.a = acc_q; mreq.b = ic_q;           end
      default:  begin mreq.a = '0;    mreq.b = '0;             end
    endcase
  end

  always_comb begin
    state_d = state_q;
    p_d = p_q;  rdy_d = rdy_q;  n_d = n_q;  m_d = m_q;
    acc_d = acc_q;  f_d = f_q;  g_d = g_q;  pa_d = pa_q;
    fa_d = fa_q;  ib_d = ib_q;  ic_d = ic_q;  rn_d = rn_q;  rm_d = rm_q;
    i_d = i_q;  k_d = k_q;  mpend_d = mpend_q;  dpend_d = dpend_q;
    ov_d = ov_q && !m_axis_tready;
    od_d = od_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    f_we = 1'b0;  f_waddr = '0;  f_wdata = '0;  f_raddr = '0;
    g_we = 1'b0;  g_waddr = '0;  g_wdata = '0;  g_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d   = s_axis_tdata[ARG_W-1:0];
          m_d   = s_axis_tdata[2*ARG_W-1:ARG_W];
          acc_d = RES_W'(1);
          if (!p_ok) begin
            acc_d   = '0;
            state_d = ST_FIN;
          end else if (!rdy_q) begin
            f_we    = 1'b1;
            f_wdata = RES_W'(1);
            f_d     = RES_W'(1);
            i_d     = MOD_W'(1);
            state_d = ST_BF;
          end else begin
            state_d = ST_CHK;
          end
        end
      end
      ST_BF: begin
        if (i_q == p_q) begin
          pa_d    = RES_W'(1);
          k_d     = BIT_W'(RES_W - 1);
          state_d = ST_PW_SQ;
        end else if (!mpend_q) begin
          mul_start = 1'b1;
          mpend_d   = 1'b1;
        end else if (mrsp.done) begin
          mpend_d = 1'b0;
          f_we    = 1'b1;
          f_waddr = AW'(i_q);
          f_wdata = mrsp.res;
          f_d     = mrsp.res;
          i_d     = i_q + 1'b1;
        end
      end
      ST_PW_SQ, ST_PW_ML: begin
        if (!mpend_q) begin
          mul_start = 1'b1;
          mpend_d   = 1'b1;
        end else if (mrsp.done) begin
          mpend_d = 1'b0;
          pa_d    = mrsp.res;
          if (state_q == ST_PW_SQ && e_pw[k_q]) begin
            state_d = ST_PW_ML;
          end else if (k_q == '0) begin
            g_we    = 1'b1;
            g_waddr = AW'(p_q - 1'b1);
            g_wdata = mrsp.res;
            g_d     = mrsp.res;
            i_d     = p_q - 1'b1;
            state_d = ST_BI;
          end else begin
            k_d     = k_q - 1'b1;
            state_d = ST_PW_SQ;
          end
        end
      end
      ST_BI: begin
        if (i_q == '0) begin
          rdy_d   = 1'b1;
          state_d = ST_CHK;
        end else if (!mpend_q) begin
          mul_start = 1'b1;
          mpend_d   = 1'b1;
        end else if (mrsp.done) begin
          mpend_d = 1'b0;
          g_we    = 1'b1;
          g_waddr = AW'(i_q - 1'b1);
          g_wdata = mrsp.res;
          g_d     = mrsp.res;
          i_d     = i_q - 1'b1;
        end
      end
      ST_CHK: begin
        state_d = (n_q == '0 && m_q == '0) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (!dpend_q) begin
          div_start = 1'b1;
          dpend_d   = 1'b1;
        end else if (drsp.done) begin
          dpend_d = 1'b0;
          n_d     = drsp.qn;
          m_d     = drsp.qm;
          rn_d    = drsp.rn;
          rm_d    = drsp.rm;
          if (drsp.rm > drsp.rn) begin
            acc_d   = '0;
            state_d = ST_FIN;
          end else begin
            state_d = ST_RD1;
          end
        end
      end
      ST_RD1: begin
        f_raddr = AW'(rn_q);
        g_raddr = AW'(rm_q);
        state_d = ST_RD2;
      end
      ST_RD2: begin
        fa_d    = f_rdata;
        ib_d    = g_rdata;
        g_raddr = AW'(rn_q - rm_q);
        state_d = ST_RD3;
      end
      ST_RD3: begin
        ic_d    = g_rdata;
        state_d = ST_M1;
      end
      ST_M1, ST_M2, ST_M3: begin
        if (!mpend_q) begin
          mul_start = 1'b1;
          mpend_d   = 1'b1;
        end else if (mrsp.done) begin
          mpend_d = 1'b0;
          acc_d   = mrsp.res;
          case (state_q)
            ST_M1:   state_d = ST_M2;
            ST_M2:   state_d = ST_M3;
            default: state_d = ST_CHK;
          endcase
        end
      end
      ST_FIN: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          od_d    = acc_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (apb_wr && paddr[2] == REG_PRIME_MODULUS) begin
      p_d   = pwdata[MOD_W-1:0];
      rdy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      p_q     <= MOD_W'(2);
      rdy_q   <= 1'b0;
      mpend_q <= 1'b0;
      dpend_q <= 1'b0;
      ov_q    <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      rdy_q   <= rdy_d;
      mpend_q <= mpend_d;
      dpend_q <= dpend_d;
      ov_q    <= ov_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;  m_q <= m_d;  acc_q <= acc_d;
    f_q <= f_d;  g_q <= g_d;  pa_q <= pa_d;
    fa_q <= fa_d;  ib_q <= ib_d;  ic_q <= ic_d;
    rn_q <= rn_d;  rm_q <= rm_d;  od_q <= od_d;
  end

  bmpl_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .p_i    (p_q),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  bmpl_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (n_q),
    .m_i     (m_q),
    .p_i     (p_q),
    .rsp_o   (drsp)
  );

  bmpl_ram #(.DEPTH(TABLE_DEPTH), .W(RES_W)) u_fact (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  bmpl_ram #(.DEPTH(TABLE_DEPTH), .W(RES_W)) u_ifact (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

endmodule
`default_nettype wire

// ===== sv/bmpl_checker.sv =====
// ----------------------------------------------------------------------------
// bmpl_checker
// Port-level checks of the Lucas binomial residue unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bmpl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  `BMPL_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped while stalled")
  `BMPL_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "output word changed while stalled")
  `BMPL_ASSERT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while a word is in work")
  `BMPL_ASSERT(a_no_early_out, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid), "result shown before work finished")
  `BMPL_ASSERT_ALWAYS(a_pready, clk_i, pready, "pready low")

endmodule

bind binomial_mod_prime_lucas_unit bmpl_checker u_bmpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lucas binomial residue unit testbench
// Directed table of words (extremes, modulus corner values, a non-prime
// modulus), then random words over a series of moduli, each result checked against
// a listed value or a behavioral model that builds its own factorial tables.
// ----------------------------------------------------------------------------
module testbench;
  import bmpl_pkg::*;

  localparam int unsigned TBL = 1024;
  localparam longint unsigned ARG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    bit              wr_mod;
    int unsigned     modv;
    longint unsigned n;
    longint unsigned m;
    bit              known;
    int unsigned     res;
  } row_t;

  logic         clk_i, rst_ni;
  logic         psel, penable, pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata, prdata;
  logic         pready;
  logic         s_axis_tvalid, s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [23:0]  m_axis_tdata;

  logic [MOD_W-1:0] cur_mod;
  bit               tbl_ok;
  longint unsigned  fact_tbl [TBL];
  longint unsigned  invf_tbl [TBL];
  logic [RES_W-1:0] residue_q [$];
  int               errs;
  bit               calm;

  binomial_mod_prime_lucas_unit #(.TABLE_DEPTH(TBL)) i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned p);
    longint unsigned acc;
    acc = 1 % p;
    b = b % p;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % p;
      b = (b * b) % p;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [RES_W-1:0] lucas_residue(longint unsigned n,
                                                     longint unsigned m);
    longint unsigned p, acc, a, b, sb;
    p = cur_mod;
    if (p < 2 || p > TBL) return '0;
    if (!tbl_ok) begin
      fact_tbl[0] = 1 % p;
      for (longint unsigned i = 1; i < p; i++) fact_tbl[i] = (fact_tbl[i-1] * i) % p;
      invf_tbl[p-1] = pow_mod(fact_tbl[p-1], p - 2, p);
      for (longint unsigned i = p - 1; i > 0; i--) invf_tbl[i-1] = (invf_tbl[i] * i) % p;
      tbl_ok = 1'b1;
    end
    acc = 1 % p;
    while (n != 0 || m != 0) begin
      a = n % p;
      b = m % p;
      if (a < b) sb = 0;
      else sb = (((fact_tbl[a] * invf_tbl[b]) % p) * invf_tbl[a-b]) % p;
      acc = (acc * sb) % p;
      n = n / p;
      m = m / p;
    end
    return acc[RES_W-1:0];
  endfunction

  task automatic write_modulus(int unsigned v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(REG_PRIME_MODULUS) * 3'd4;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_mod = v[MOD_W-1:0];
    tbl_ok  = 1'b0;
  endtask

  task automatic drain();
    while (residue_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_word(longint unsigned n, longint unsigned m, bit known,
                           int unsigned res);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, m[62:0], n[62:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (known) residue_q.push_back(res[RES_W-1:0]);
    else residue_q.push_back(lucas_residue(n, m));
  endtask

  task automatic random_phase(int unsigned modv, int count);
    longint unsigned n, m, pw, p, dn, dm;
    bit shaped;
    int nd;
    drain();
    s_axis_tvalid <= 1'b0;
    write_modulus(modv);
    p = modv & 32'h1F_FFFF;
    for (int k = 0; k < count; k++) begin
      if (p >= 2 && p <= TBL && $urandom_range(0, 9) != 0) begin
        shaped = ($urandom_range(0, 9) < 8);
        nd = $urandom_range(1, 63);
        n = 0; m = 0; pw = 1;
        for (int d = 0; d < nd && pw <= ARG_MAX / p; d++) begin
          dn = $urandom % p;
          dm = shaped ? $urandom_range(0, int'(dn)) : $urandom % p;
          n += dn * pw;
          m += dm * pw;
          pw *= p;
        end
      end else begin
        n = {$urandom, $urandom} & ARG_MAX;
        m = {$urandom, $urandom} & ARG_MAX;
        n = n >> $urandom_range(0, 62);
        m = m >> $urandom_range(0, 62);
      end
      send_word(n, m, 1'b0, 0);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (residue_q.size() == 0) begin
        $error("binomial_residue: unexpected word %0d", m_axis_tdata[RES_W-1:0]);
        errs++;
      end else begin
        if (m_axis_tdata[RES_W-1:0] !== residue_q[0]) begin
          $error("binomial_residue: expected %0d, actual %0d", residue_q[0],
                 m_axis_tdata[RES_W-1:0]);
          errs++;
        end
        void'(residue_q.pop_front());
      end
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  initial begin
    row_t rows [$];
    rows = '{
      '{0, 0, 0, 0, 1, 1},
      '{0, 0, ARG_MAX, ARG_MAX, 1, 1},
      '{0, 0, ARG_MAX, 0, 1, 1},
      '{0, 0, 0, ARG_MAX, 1, 0},
      '{0, 0, 5, 3, 0, 0},
      '{1, 3, 0, 0, 1, 1},
      '{0, 0, ARG_MAX, 1, 0, 0},
      '{0, 0, 10, 4, 0, 0},
      '{1, 1021, 1020, 510, 0, 0},
      '{0, 0, ARG_MAX, ARG_MAX, 1, 1},
      '{0, 0, ARG_MAX, 0, 1, 1},
      '{0, 0, 64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA, 0, 0},
      '{1, 0, ARG_MAX, 5, 1, 0},
      '{1, 1, 7, 3, 1, 0},
      '{1, 32'h1F_FFFF, 9, 4, 1, 0},
      '{1, 1048576, ARG_MAX, 3, 1, 0},
      '{1, 1025, 100, 50, 1, 0},
      '{1, 1024, 1023, 7, 0, 0},
      '{1, 1000, 999, 3, 0, 0},
      '{0, 0, 0, 0, 1, 1},
      '{0, 0, 123456789, 1234, 0, 0}
    };
    errs = 0;
    calm = 1'b0;
    cur_mod = 2;
    tbl_ok = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].wr_mod) begin
        s_axis_tvalid <= 1'b0;
        drain();
        write_modulus(rows[i].modv);
      end
      send_word(rows[i].n, rows[i].m, rows[i].known, rows[i].res);
    end
    s_axis_tvalid <= 1'b0;

    random_phase(2, 12);
    random_phase(3, 30);
    random_phase(5, 25);
    random_phase(0, 8);
    random_phase(1021, 30);
    random_phase(97, 30);
    random_phase(1000, 15);
    random_phase(32'h1F_FFFF, 8);
    random_phase(13, 30);
    random_phase(251, 30);
    drain();
    calm = 1'b1;
    random_phase(7, 40);

    drain();
    repeat (200) @(posedge clk_i);
    if (errs == 0 && residue_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
